// File: src/cfr_pkg.sv
// Package for the checked frame receiver: parser phases, register indexes,
// the result record and frame constants. No dependencies.
package cfr_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned LenW  = 9;
  localparam int unsigned CfgIdxW = 2;

  // Header, address, function, length, running sum and sum of sums.
  localparam logic [LenW-1:0] OverheadBytes = 9'd6;

  localparam logic [ByteW-1:0] HeaderReset  = 8'd170;
  localparam logic [ByteW-1:0] AddressReset = 8'd255;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_HEADER  = 2'd0,
    CFG_ADDRESS = 2'd1
  } cfg_index_t;

  typedef enum logic [2:0] {
    PH_HUNT = 3'd0,
    PH_ADDR = 3'd1,
    PH_FUNC = 3'd2,
    PH_LEN  = 3'd3,
    PH_PAY  = 3'd4,
    PH_SUM  = 3'd5,
    PH_SUM2 = 3'd6
  } phase_t;

  typedef struct packed {
    logic [ByteW-1:0] function_code;
    logic [ByteW-1:0] payload_index;
    logic [ByteW-1:0] payload_byte;
    logic             end_of_frame;
    logic             frame_good;
    logic [LenW-1:0]  frame_length;
  } result_t;

endpackage

// File: src/checked_frame_receiver_core.sv
// Top level of the checked frame receiver: input register, config registers,
// parser and result register. Depends on cfr_pkg and cfr_parse.
//
//   channel  direction  handshake             payload
//   input    in         in_valid / in_stall   rx_byte
//   result   out        out_valid / out_stall function_code .. frame_length
//   config   in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// One byte per cycle while no stalled result holds it; the edge that parses a held byte
// also loads its result, if any, into the result register.
// The parser step is a single 8-bit add pair and compare between registers.
// Reset is synchronous: phase returns to header hunting, both item registers empty.
// A stalled result holds the parser; in_stall rises only when a byte waits too.
module checked_frame_receiver_core import cfr_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [ByteW-1:0]   rx_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [ByteW-1:0]   function_code,
  output logic [ByteW-1:0]   payload_index,
  output logic [ByteW-1:0]   payload_byte,
  output logic               end_of_frame,
  output logic               frame_good,
  output logic [LenW-1:0]    frame_length,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [ByteW-1:0]   cfg_data
);

  logic [ByteW-1:0] header_byte;
  logic [ByteW-1:0] address_byte;
  logic             s1_valid;
  logic [ByteW-1:0] s1_byte;
  logic             out_free;
  logic             step;
  logic             res_valid;
  result_t          res;
  result_t          out_res;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || !out_stall;
  assign step      = s1_valid && out_free;
  assign in_stall  = s1_valid && !out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_byte  <= HeaderReset;
      address_byte <= AddressReset;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_HEADER:  header_byte  <= cfg_data;
        CFG_ADDRESS: address_byte <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register: refill whenever the held byte moves on
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_byte <= rx_byte;
    end
  end

  cfr_parse u_parse (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .rx_byte      (s1_byte),
    .header_byte  (header_byte),
    .address_byte (address_byte),
    .res_valid    (res_valid),
    .res          (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= step && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && step && res_valid) begin
      out_res <= res;
    end
  end

  assign function_code = out_res.function_code;
  assign payload_index = out_res.payload_index;
  assign payload_byte  = out_res.payload_byte;
  assign end_of_frame  = out_res.end_of_frame;
  assign frame_good    = out_res.frame_good;
  assign frame_length  = out_res.frame_length;

endmodule

// File: src/cfr_parse.sv
// Frame parser state and per-byte step logic for the checked frame receiver.
// Depends on cfr_pkg.
module cfr_parse import cfr_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic [ByteW-1:0] rx_byte,
  input  logic [ByteW-1:0] header_byte,
  input  logic [ByteW-1:0] address_byte,
  output logic             res_valid,
  output result_t          res
);

  phase_t           phase, phase_next;
  logic [ByteW-1:0] held_function, held_function_next;
  logic [ByteW-1:0] held_length, held_length_next;
  logic [ByteW-1:0] byte_count, byte_count_next;
  logic [ByteW-1:0] running_sum, running_sum_next;
  logic [ByteW-1:0] sum_of_sums, sum_of_sums_next;
  logic [ByteW-1:0] received_sum, received_sum_next;

  logic [ByteW-1:0] count_inc;
  logic [ByteW-1:0] acc_sum;
  logic [ByteW-1:0] acc_sos;
  logic [ByteW-1:0] hdr_sum;

  assign count_inc = byte_count + 8'd1;
  assign acc_sum   = running_sum + rx_byte;
  assign acc_sos   = sum_of_sums + acc_sum;
  // A header restarts both sums from zero before adding itself.
  assign hdr_sum   = rx_byte;

  // Next phase
  always_comb begin
    case (phase)
      PH_ADDR: phase_next = (rx_byte == address_byte) ? PH_FUNC : PH_HUNT;
      PH_FUNC: phase_next = PH_LEN;
      PH_LEN:  phase_next = (rx_byte == '0) ? PH_SUM : PH_PAY;
      PH_PAY:  phase_next = (count_inc == held_length) ? PH_SUM : PH_PAY;
      PH_SUM:  phase_next = PH_SUM2;
      PH_SUM2: phase_next = PH_HUNT;
      default: phase_next = (rx_byte == header_byte) ? PH_ADDR : PH_HUNT;
    endcase
  end

  // Datapath and result
  always_comb begin
    held_function_next = held_function;
    held_length_next   = held_length;
    byte_count_next    = byte_count;
    running_sum_next   = running_sum;
    sum_of_sums_next   = sum_of_sums;
    received_sum_next  = received_sum;
    res_valid          = 1'b0;
    res                = '0;
    res.function_code  = held_function;
    case (phase)
      PH_ADDR: begin
        if (rx_byte == address_byte) begin
          running_sum_next = acc_sum;
          sum_of_sums_next = acc_sos;
        end
      end
      PH_FUNC: begin
        running_sum_next   = acc_sum;
        sum_of_sums_next   = acc_sos;
        held_function_next = rx_byte;
      end
      PH_LEN: begin
        running_sum_next = acc_sum;
        sum_of_sums_next = acc_sos;
        held_length_next = rx_byte;
        byte_count_next  = '0;
      end
      PH_PAY: begin
        running_sum_next  = acc_sum;
        sum_of_sums_next  = acc_sos;
        byte_count_next   = count_inc;
        res_valid         = 1'b1;
        res.payload_index = byte_count;
        res.payload_byte  = rx_byte;
      end
      PH_SUM: begin
        received_sum_next = rx_byte;
      end
      PH_SUM2: begin
        res_valid        = 1'b1;
        res.end_of_frame = 1'b1;
        res.frame_good   = (received_sum == running_sum) && (rx_byte == sum_of_sums);
        res.frame_length = {1'b0, held_length} + OverheadBytes;
      end
      default: begin
        if (rx_byte == header_byte) begin
          running_sum_next = hdr_sum;
          sum_of_sums_next = hdr_sum;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HUNT;
      held_function <= '0;
      held_length   <= '0;
      byte_count    <= '0;
      running_sum   <= '0;
      sum_of_sums   <= '0;
      received_sum  <= '0;
    end else if (step) begin
      phase         <= phase_next;
      held_function <= held_function_next;
      held_length   <= held_length_next;
      byte_count    <= byte_count_next;
      running_sum   <= running_sum_next;
      sum_of_sums   <= sum_of_sums_next;
      received_sum  <= received_sum_next;
    end
  end

endmodule

// File: src/cfr_check.sv
// Port-level checker for checked_frame_receiver_core, bound to the top level.
// Depends on cfr_pkg.
module cfr_check import cfr_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input logic [ByteW-1:0] payload_index,
  input logic [ByteW-1:0] payload_byte,
  input logic             end_of_frame,
  input logic             frame_good,
  input logic [LenW-1:0]  frame_length
);

  // A stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(frame_length) && $stable(payload_byte))
    else $error("stalled result changed");

  // Back-pressure only passes through from a stalled full result register
  a_stall_src: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a stalled result");

  a_verdict: assert property (@(posedge clk) disable iff (rst)
    out_valid && end_of_frame |->
      frame_length >= OverheadBytes && payload_byte == '0 && payload_index == '0)
    else $error("malformed verdict");

  a_payload: assert property (@(posedge clk) disable iff (rst)
    out_valid && !end_of_frame |-> !frame_good && frame_length == '0)
    else $error("malformed payload item");

  a_reset: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result valid straight after reset");

endmodule

bind checked_frame_receiver_core cfr_check u_cfr_check (
  .clk           (clk),
  .rst           (rst),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .payload_index (payload_index),
  .payload_byte  (payload_byte),
  .end_of_frame  (end_of_frame),
  .frame_good    (frame_good),
  .frame_length  (frame_length)
);

// File: bench/cfr_frame_checker.sv
// Frame checker for the checked frame receiver: watches the byte, result and
// register channels, tracks the parser and compares every result it accepts.
// Depends on cfr_pkg.
module cfr_frame_checker import cfr_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [ByteW-1:0]   rx_byte,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [ByteW-1:0]   function_code,
  input  logic [ByteW-1:0]   payload_index,
  input  logic [ByteW-1:0]   payload_byte,
  input  logic               end_of_frame,
  input  logic               frame_good,
  input  logic [LenW-1:0]    frame_length,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [ByteW-1:0]   cfg_data,
  output int                 mismatch_count,
  output int                 results_due
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [ByteW-1:0] want_header;
  logic [ByteW-1:0] want_address;
  phase_t           phase;
  logic [ByteW-1:0] func_q;
  logic [ByteW-1:0] len_q;
  logic [ByteW-1:0] count_q;
  logic [ByteW-1:0] sum_q;
  logic [ByteW-1:0] sum2_q;
  logic [ByteW-1:0] rx_sum_q;
  result_t          due_results[$];

  task automatic fold_in(input logic [ByteW-1:0] b);
    sum_q  = sum_q + b;
    sum2_q = sum2_q + sum_q;
  endtask

  task automatic parse_rx_byte(input logic [ByteW-1:0] b);
    result_t r;
    r = '0;
    case (phase)
      PH_ADDR: begin
        // a wrong address is dropped, not retried as a header
        if (b == want_address) begin
          fold_in(b);
          phase = PH_FUNC;
        end else begin
          phase = PH_HUNT;
        end
      end
      PH_FUNC: begin
        fold_in(b);
        func_q = b;
        phase  = PH_LEN;
      end
      PH_LEN: begin
        fold_in(b);
        len_q   = b;
        count_q = '0;
        phase   = (b == '0) ? PH_SUM : PH_PAY;
      end
      PH_PAY: begin
        fold_in(b);
        r.function_code = func_q;
        r.payload_index = count_q;
        r.payload_byte  = b;
        due_results.push_back(r);
        count_q = count_q + 8'd1;
        if (count_q == len_q) phase = PH_SUM;
      end
      PH_SUM: begin
        rx_sum_q = b;
        phase    = PH_SUM2;
      end
      PH_SUM2: begin
        r.function_code = func_q;
        r.end_of_frame  = 1'b1;
        r.frame_good    = (rx_sum_q == sum_q) && (b == sum2_q);
        r.frame_length  = {1'b0, len_q} + OverheadBytes;
        due_results.push_back(r);
        phase = PH_HUNT;
      end
      default: begin
        if (b == want_header) begin
          sum_q  = '0;
          sum2_q = '0;
          fold_in(b);
          phase = PH_ADDR;
        end else begin
          phase = PH_HUNT;
        end
      end
    endcase
  endtask

  task automatic compare_field(input string name, input logic [LenW-1:0] want_v,
                               input logic [LenW-1:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t ns: %s expected %0d, actual %0d", $time, name, want_v, got_v);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      want_header  = HeaderReset;
      want_address = AddressReset;
      phase        = PH_HUNT;
      func_q       = '0;
      len_q        = '0;
      count_q      = '0;
      sum_q        = '0;
      sum2_q       = '0;
      rx_sum_q     = '0;
      due_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          $display("%0t ns: result expected none, actual fc=%0d idx=%0d byte=%0d eof=%0b",
                   $time, function_code, payload_index, payload_byte, end_of_frame);
          mismatch_count++;
        end else begin
          want = due_results.pop_front();
          compare_field("function_code", LenW'(want.function_code), LenW'(function_code));
          compare_field("payload_index", LenW'(want.payload_index), LenW'(payload_index));
          compare_field("payload_byte", LenW'(want.payload_byte), LenW'(payload_byte));
          compare_field("end_of_frame", LenW'(want.end_of_frame), LenW'(end_of_frame));
          compare_field("frame_good", LenW'(want.frame_good), LenW'(frame_good));
          compare_field("frame_length", want.frame_length, frame_length);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_HEADER:  want_header = cfg_data;
          CFG_ADDRESS: want_address = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) parse_rx_byte(rx_byte);
    end
    results_due = due_results.size();
  end

endmodule

// File: bench/tb_checked_frame_receiver_core.sv
// Testbench top for checked_frame_receiver_core: drives byte frames, register
// writes and result stalls; the frame checker does prediction and comparison.
// Depends on cfr_pkg, checked_frame_receiver_core and cfr_frame_checker.
module tb_checked_frame_receiver_core;
  import cfr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WatchdogLimit = 1000;
  localparam int HoldCycles    = 60;
  localparam int SettleCycles  = 8;
  localparam int ItemsPerPhase = 20;

  typedef enum logic [1:0] {
    FLAW_NONE,
    FLAW_SUM,
    FLAW_SUM_OF_SUMS
  } frame_flaw_t;

  logic               clk = 1'b0;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic [ByteW-1:0]   rx_byte;
  logic               out_valid;
  logic               out_stall;
  logic [ByteW-1:0]   function_code;
  logic [ByteW-1:0]   payload_index;
  logic [ByteW-1:0]   payload_byte;
  logic               end_of_frame;
  logic               frame_good;
  logic [LenW-1:0]    frame_length;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index;
  logic [ByteW-1:0]   cfg_data;
  int                 mismatch_count;
  int                 results_due;

  logic               tx_pace = 1'b0;
  logic               rx_pace = 1'b0;
  logic               hold_req = 1'b0;
  logic [ByteW-1:0]   cur_header;
  logic [ByteW-1:0]   cur_address;
  logic [ByteW-1:0]   line_bytes[$];

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  checked_frame_receiver_core uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .rx_byte(rx_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .function_code(function_code), .payload_index(payload_index),
    .payload_byte(payload_byte), .end_of_frame(end_of_frame),
    .frame_good(frame_good), .frame_length(frame_length),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  cfr_frame_checker frame_check (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .rx_byte(rx_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .function_code(function_code), .payload_index(payload_index),
    .payload_byte(payload_byte), .end_of_frame(end_of_frame),
    .frame_good(frame_good), .frame_length(frame_length),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatch_count(mismatch_count), .results_due(results_due)
  );

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 2) return 255;
    if (r < 20) return 0;
    return $urandom_range(1, 12);
  endfunction

  // Queue a frame built on the current register values, both sums over all bytes before them.
  task automatic queue_frame(input logic [ByteW-1:0] func, input int len,
                             input frame_flaw_t flaw, input logic ones_payload);
    logic [ByteW-1:0] body[$];
    logic [ByteW-1:0] rs;
    logic [ByteW-1:0] ss;
    body.push_back(cur_header);
    body.push_back(cur_address);
    body.push_back(func);
    body.push_back(len[ByteW-1:0]);
    repeat (len) body.push_back(ones_payload ? 8'hFF : 8'($urandom));
    rs = '0;
    ss = '0;
    foreach (body[i]) begin
      rs = rs + body[i];
      ss = ss + rs;
      line_bytes.push_back(body[i]);
    end
    if (flaw == FLAW_SUM) rs = rs ^ 8'($urandom_range(1, 255));
    if (flaw == FLAW_SUM_OF_SUMS) ss = ss ^ 8'($urandom_range(1, 255));
    line_bytes.push_back(rs);
    line_bytes.push_back(ss);
  endtask

  // Entered and left just after a falling edge.
  task automatic send_byte(input logic [ByteW-1:0] b);
    int gap;
    if (tx_pace && $urandom_range(0, 2) == 0) gap = pick_gap();
    else gap = 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic send_queued();
    while (line_bytes.size() != 0) send_byte(line_bytes.pop_front());
  endtask

  // Drop valid, drain results, then let the pipe settle with no bytes sent.
  task automatic go_idle();
    in_valid <= 1'b0;
    while (results_due != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [ByteW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_HEADER) cur_header = val;
    else cur_address = val;
    @(negedge clk);
  endtask

  task automatic random_phase(input int quota);
    int sent;
    int pick;
    int len;
    int r;
    frame_flaw_t flaw;
    sent = 0;
    while (sent < quota) begin
      tx_pace = ($urandom_range(0, 3) != 0);
      rx_pace = ($urandom_range(0, 3) != 0);
      pick = $urandom_range(0, 99);
      len  = pick_len();
      if (pick < 70) begin
        r = $urandom_range(0, 9);
        flaw = (r < 7) ? FLAW_NONE : (r < 9) ? FLAW_SUM : FLAW_SUM_OF_SUMS;
        queue_frame(8'($urandom), len, flaw, 1'b0);
        sent += len + 6;
      end else if (pick < 80) begin
        repeat ($urandom_range(1, 4)) line_bytes.push_back(8'($urandom));
      end else if (pick < 90) begin
        line_bytes.push_back(cur_header);
        line_bytes.push_back(cur_address ^ 8'($urandom_range(1, 255)));
      end else begin
        // cut the frame short; what follows lands mid-frame
        queue_frame(8'($urandom), len, FLAW_NONE, 1'b0);
        repeat ($urandom_range(1, len + 2)) void'(line_bytes.pop_back());
      end
      send_queued();
    end
  endtask

  initial begin
    int n;
    logic hold_done;
    hold_done = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        out_stall <= 1'b1;
        repeat (HoldCycles) @(negedge clk);
        hold_done = 1'b1;
        out_stall <= 1'b0;
      end else if (rx_pace && $urandom_range(0, 3) == 0) begin
        n = pick_gap();
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WatchdogLimit) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("tb_checked_frame_receiver_core: done, errors");
    $finish;
  end

  initial begin
    rst         = 1'b1;
    in_valid    = 1'b0;
    rx_byte     = '0;
    cfg_valid   = 1'b0;
    cfg_index   = CFG_HEADER;
    cfg_data    = '0;
    cur_header  = HeaderReset;
    cur_address = AddressReset;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: stray byte, header value where the address belongs,
    // empty frame, single all-ones payload, bad sum-of-sums
    line_bytes.push_back(8'h00);
    line_bytes.push_back(cur_header);
    line_bytes.push_back(cur_header);
    queue_frame(8'h00, 0, FLAW_NONE, 1'b0);
    queue_frame(8'hFF, 1, FLAW_NONE, 1'b1);
    queue_frame(8'h5A, 0, FLAW_SUM_OF_SUMS, 1'b0);
    send_queued();
    go_idle();

    random_phase(ItemsPerPhase);
    go_idle();

    write_reg(CFG_HEADER, 8'h00);
    write_reg(CFG_ADDRESS, 8'h00);
    // hold the result side while bytes keep coming, so the input backs up
    tx_pace  = 1'b0;
    hold_req = 1'b1;
    queue_frame(8'($urandom), 40, FLAW_NONE, 1'b0);
    send_queued();
    random_phase(ItemsPerPhase);
    go_idle();

    write_reg(CFG_HEADER, 8'hFF);
    write_reg(CFG_ADDRESS, 8'hFF);
    random_phase(ItemsPerPhase);
    go_idle();

    write_reg(CFG_HEADER, 8'($urandom));
    write_reg(CFG_ADDRESS, 8'($urandom));
    tx_pace = 1'b1;
    rx_pace = 1'b1;
    queue_frame(8'($urandom), 255, FLAW_NONE, 1'b0);
    send_queued();
    random_phase(ItemsPerPhase);
    go_idle();

    if (mismatch_count == 0 && results_due == 0) begin
      $display("tb_checked_frame_receiver_core: done, clean");
    end else begin
      $display("tb_checked_frame_receiver_core: done, errors");
    end
    $finish;
  end

endmodule
